/* sv/shear_scanline_resampler_macros.svh */
// Assertion macros shared by the shear scanline resampler RTL.
// Included by modules that carry concurrent checks; expects clk and rst_n in scope.
`ifndef SHEAR_SCANLINE_RESAMPLER_MACROS_SVH
`define SHEAR_SCANLINE_RESAMPLER_MACROS_SVH

// Same-cycle implication, quiet while reset is held.
`define SSR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet while reset is held.
`define SSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/ssr_pkg.sv */
// Shared types and constants for the shear scanline resampler.
// No dependencies; imported by all RTL modules and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package ssr_pkg;

  localparam int MAX_LINE_WIDTH = 16384;
  localparam logic [16:0] LINE_W_MAX = 17'(MAX_LINE_WIDTH);

  localparam int PIX_W = 8;
  localparam int POS_W = 14;
  localparam int CH_W  = 2;
  localparam int NCH_W = 3;
  localparam int CW_W  = 17;

  // configuration register indexes
  localparam logic [0:0] REG_CHANNEL_COUNT = 1'b0;
  localparam logic [0:0] REG_DEST_WIDTH    = 1'b1;

  // what one input sample produces, handed from engine to output buffer
  typedef struct packed {
    logic             main_en;
    logic [PIX_W-1:0] main_pix;
    logic [POS_W-1:0] main_pos;
    logic [CH_W-1:0]  main_ch;
    logic             tail_en;
    logic [POS_W-1:0] tail_pos;
    logic [NCH_W-1:0] nch;
  } res_ctrl_t;

  // one output beat
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [POS_W-1:0] pos;
    logic [CH_W-1:0]  chan;
    logic             tail;
  } res_t;

endpackage

`default_nettype wire

/* sv/ssr_engine.sv */
// Per-sample datapath and line state: multiply-add, rounding, leftover update.
// Depends on ssr_pkg and shear_scanline_resampler_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "shear_scanline_resampler_macros.svh"

module ssr_engine #(
  parameter int MAX_CHANNELS = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go_i,
  input  logic [7:0]           sample_i,
  input  logic                 first_i,
  input  logic                 last_i,
  input  logic signed [15:0]   offset_i,
  input  logic [16:0]          weight_i,
  input  logic [2:0]           nch_i,
  input  logic [16:0]          width_i,
  output ssr_pkg::res_ctrl_t   ctrl_o,
  output logic [7:0]           tail_pix_o [MAX_CHANNELS]
);
  import ssr_pkg::*;

  localparam logic signed [27:0] HALF    = 28'sd32768;
  localparam logic signed [15:0] CTR_MAX = 16'sd32767;

  function automatic logic signed [11:0] rnd_div(input logic signed [27:0] t);
    logic signed [27:0] a;
    a = t[27] ? (t + 28'sd65535) : t;   // truncate toward zero
    return a[27:16];
  endfunction

  function automatic logic [7:0] clamp_pix(input logic signed [11:0] v);
    logic [7:0] r;
    if (v < 12'sd0)        r = 8'h00;
    else if (v > 12'sd255) r = 8'hFF;
    else                   r = v[7:0];
    return r;
  endfunction

  function automatic logic signed [25:0] sat_left(input logic signed [29:0] v);
    logic signed [25:0] r;
    if (v > 30'sd33554431)       r = 26'sd33554431;
    else if (v < -30'sd33554432) r = -26'sd33554432;
    else                         r = v[25:0];
    return r;
  endfunction

  logic signed [25:0] left_r   [MAX_CHANNELS];
  logic signed [25:0] left_nxt [MAX_CHANNELS];
  logic signed [15:0] ctr_r, ctr_nxt;
  logic [CH_W-1:0]    ch_r, ch_nxt;
  logic [16:0]        wgt_r, wgt_nxt;
  logic               stop_r, stop_nxt;

  logic               fst;
  logic signed [25:0] left_e [MAX_CHANNELS];
  logic signed [15:0] ctr_e, ctr_n, tpos;
  logic [CH_W-1:0]    ch_e0, ch_e, ch_n;
  logic [2:0]         ch_inc;
  logic               stop_e, pos_ge_w, act, wrap, tail_ok;
  logic signed [25:0] l_cur, l_new;
  logic [24:0]        prod;
  logic signed [27:0] total;
  logic signed [11:0] val;
  logic signed [12:0] diff;
  logic signed [29:0] upd;

  always_comb begin
    fst    = go_i && first_i;
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      left_e[i] = fst ? '0 : left_r[i];
    end
    ctr_e  = fst ? offset_i : ctr_r;
    wgt_nxt = fst ? weight_i : wgt_r;
    ch_e0  = fst ? '0 : ch_r;
    stop_e = fst ? 1'b0 : stop_r;
    ch_e   = ({1'b0, ch_e0} >= nch_i) ? '0 : ch_e0;

    pos_ge_w = !ctr_e[15] && ({1'b0, ctr_e} >= width_i);
    act      = go_i && !stop_e && !pos_ge_w;

    l_cur = '0;
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      if (ch_e == CH_W'(i)) l_cur = left_e[i];
    end

    // leftover + sample*weight + 0.5, Q.16
    prod  = sample_i * wgt_nxt;
    total = {{2{l_cur[25]}}, l_cur} + {3'b000, prod} + HALF;
    val   = rnd_div(total);
    diff  = $signed({5'b00000, sample_i}) - val;
    upd   = {{4{l_cur[25]}}, l_cur} + {diff[12], diff, 16'h0000};
    l_new = sat_left(upd);

    ch_inc = {1'b0, ch_e} + 3'd1;
    wrap   = ch_inc >= nch_i;
    ch_n   = wrap ? '0 : ch_inc[CH_W-1:0];
    ctr_n  = (wrap && ctr_e != CTR_MAX) ? ctr_e + 16'sd1 : ctr_e;
    // a partly filled pixel counts as complete for the tail
    tpos   = (ch_n != '0 && ctr_n != CTR_MAX) ? ctr_n + 16'sd1 : ctr_n;
    tail_ok = !tpos[15] && ({1'b0, tpos} < width_i);

    for (int i = 0; i < MAX_CHANNELS; i++) begin
      left_nxt[i] = left_e[i];
      if (act && ch_e == CH_W'(i)) left_nxt[i] = l_new;
    end
    ctr_nxt  = ctr_e;
    ch_nxt   = ch_e0;
    stop_nxt = stop_e;
    if (go_i && !stop_e) begin
      ch_nxt = ch_e;
      if (pos_ge_w) begin
        stop_nxt = 1'b1;
      end else begin
        ch_nxt  = ch_n;
        ctr_nxt = ctr_n;
        if (last_i) stop_nxt = 1'b1;
      end
    end

    ctrl_o.main_en  = act && !ctr_e[15];
    ctrl_o.main_pix = clamp_pix(val);
    ctrl_o.main_pos = ctr_e[POS_W-1:0];
    ctrl_o.main_ch  = ch_e;
    ctrl_o.tail_en  = act && last_i && tail_ok;
    ctrl_o.tail_pos = tpos[POS_W-1:0];
    ctrl_o.nch      = nch_i;

    for (int i = 0; i < MAX_CHANNELS; i++) begin
      tail_pix_o[i] = clamp_pix(rnd_div({{2{left_nxt[i][25]}}, left_nxt[i]} + HALF));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_CHANNELS; i++) left_r[i] <= '0;
      ctr_r  <= '0;
      ch_r   <= '0;
      wgt_r  <= '0;
      stop_r <= 1'b0;
    end else begin
      for (int i = 0; i < MAX_CHANNELS; i++) left_r[i] <= left_nxt[i];
      ctr_r  <= ctr_nxt;
      ch_r   <= ch_nxt;
      wgt_r  <= wgt_nxt;
      stop_r <= stop_nxt;
    end
  end

  `SSR_ASSERT_NEXT(a_last_stops_line, go_i && last_i, stop_r, "line not stopped after last sample")
  `SSR_ASSERT_NOW(a_stopped_silent, go_i && !first_i && stop_r, !ctrl_o.main_en && !ctrl_o.tail_en, "stopped line produced a result")

endmodule

`default_nettype wire

/* sv/ssr_outbuf.sv */
// Result register: holds every beat one sample produces and plays them out in order.
// Depends on ssr_pkg and shear_scanline_resampler_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "shear_scanline_resampler_macros.svh"

module ssr_outbuf #(
  parameter int MAX_CHANNELS = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                ld_i,
  input  ssr_pkg::res_ctrl_t  ctrl_i,
  input  logic [7:0]          tail_pix_i [MAX_CHANNELS],
  output logic                free_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                out_last_o,
  output ssr_pkg::res_t       out_res_o
);
  import ssr_pkg::*;

  localparam int NR = MAX_CHANNELS + 1;
  localparam int RW = $clog2(NR + 1);
  localparam int IW = $clog2(NR);

  res_t          ent_r  [NR];
  res_t          ent_ld [NR];
  res_t          tl     [MAX_CHANNELS];
  res_t          mn;
  logic [RW-1:0] rem_r, rem_nxt, n_ld;
  logic [IW-1:0] rd_r, rd_nxt;
  logic          hs;

  always_comb begin
    mn = '{pixel: ctrl_i.main_pix, pos: ctrl_i.main_pos, chan: ctrl_i.main_ch, tail: 1'b0};
    for (int j = 0; j < MAX_CHANNELS; j++) begin
      tl[j] = '{pixel: tail_pix_i[j], pos: ctrl_i.tail_pos, chan: CH_W'(j), tail: 1'b1};
    end
    // main beat first when present, tails follow in channel order
    ent_ld[0] = ctrl_i.main_en ? mn : tl[0];
    for (int k = 1; k < NR - 1; k++) begin
      ent_ld[k] = ctrl_i.main_en ? tl[k-1] : tl[k];
    end
    ent_ld[NR-1] = tl[MAX_CHANNELS-1];
    n_ld = RW'(ctrl_i.main_en) + (ctrl_i.tail_en ? RW'(ctrl_i.nch) : '0);
  end

  assign out_valid_o = rem_r != '0;
  assign out_last_o  = rem_r == RW'(1);
  assign out_res_o   = ent_r[rd_r];
  assign hs          = out_valid_o && out_ready_i;
  assign free_o      = (rem_r == '0) || (out_last_o && out_ready_i);

  always_comb begin
    rem_nxt = rem_r;
    rd_nxt  = rd_r;
    if (ld_i) begin
      rem_nxt = n_ld;
      rd_nxt  = '0;
    end else if (hs) begin
      rem_nxt = rem_r - RW'(1);
      rd_nxt  = rd_r + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
      rd_r  <= '0;
    end else begin
      rem_r <= rem_nxt;
      rd_r  <= rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_i) ent_r <= ent_ld;
  end

  `SSR_ASSERT_NEXT(a_empty_load, ld_i && !ctrl_i.main_en && !ctrl_i.tail_en, !out_valid_o, "beat shown for a sample with no result")
  `SSR_ASSERT_NEXT(a_drain_done, hs && out_last_o && !ld_i, !out_valid_o, "beat shown after final beat drained")

endmodule

`default_nettype wire

/* sv/shear_scanline_resampler.sv */
// Top level of the shear scanline resampler: ports, config registers, input register.
// Depends on ssr_pkg, ssr_engine and ssr_outbuf.
//
//   channel  dir   beat contents
//   in_*     in    tdata: sample[7:0], line_offset[23:8], line_weight[40:24];
//                  tuser: first_of_line; tlast: last_of_line
//   out_*    out   tdata: pixel[7:0], dest_position[21:8], channel[23:22];
//                  tuser: is_tail; tlast: last_of_run
//   cfg_*    in    write port, index 0 channel_count, index 1 dest_width
//
// One sample per clock while each sample yields at most one beat and the output is
// ready; the output port sets the pace otherwise: a last_of_line sample with tails
// holds the buffer for up to 1 + channel-count beats. The path holds the input
// register and the result register. The per-channel leftover is updated through
// one 8x17 multiply-add and registered for the next sample of its channel.
// Reset (rst_n low, synchronous) clears line state and sets channel_count=1,
// dest_width=16384. A stalled output holds its beat; input takes a new beat while
// the input register is empty or the result register can be refilled this cycle.
`timescale 1ns / 1ps
`default_nettype none

module shear_scanline_resampler #(
  parameter int MAX_CHANNELS = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // sample[7:0], line_offset[23:8], line_weight[40:24]
  input  logic        in_tuser,   // first_of_line
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // pixel[7:0], dest_position[21:8], channel[23:22]
  output logic        out_tuser,  // is_tail
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [14:0] cfg_wdata
);
  import ssr_pkg::*;

  localparam logic [NCH_W-1:0] MAXC = NCH_W'(MAX_CHANNELS);

  // config registers
  logic [1:0]  chan_cnt_r;
  logic [14:0] dest_width_r;

  // input register
  logic               s0_valid_r, s0_valid_nxt;
  logic [7:0]         s0_sample_r;
  logic               s0_first_r, s0_last_r;
  logic signed [15:0] s0_off_r;
  logic [16:0]        s0_wgt_r;

  logic             buf_free, go, in_hs;
  logic [NCH_W-1:0] nch;
  logic [CW_W-1:0]  width_eff;
  res_ctrl_t        ctrl;
  logic [7:0]       tail_pix [MAX_CHANNELS];
  res_t             out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_cnt_r   <= 2'd1;
      dest_width_r <= 15'd16384;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CHANNEL_COUNT: chan_cnt_r   <= cfg_wdata[1:0];
        REG_DEST_WIDTH:    dest_width_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // zero channels act as one; widths past the line limit act as the limit
  always_comb begin
    if (chan_cnt_r == 2'd0)               nch = NCH_W'(1);
    else if ({1'b0, chan_cnt_r} > MAXC)   nch = MAXC;
    else                                  nch = {1'b0, chan_cnt_r};
    width_eff = ({2'b00, dest_width_r} > LINE_W_MAX) ? LINE_W_MAX : {2'b00, dest_width_r};
  end

  assign go        = s0_valid_r && buf_free;
  assign in_tready = !s0_valid_r || buf_free;
  assign in_hs     = in_tvalid && in_tready;

  always_comb begin
    s0_valid_nxt = s0_valid_r;
    if (in_hs)   s0_valid_nxt = 1'b1;
    else if (go) s0_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s0_valid_r <= 1'b0;
    else        s0_valid_r <= s0_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_hs) begin
      s0_sample_r <= in_tdata[7:0];
      s0_off_r    <= in_tdata[23:8];
      s0_wgt_r    <= in_tdata[40:24];
      s0_first_r  <= in_tuser;
      s0_last_r   <= in_tlast;
    end
  end

  ssr_engine #(.MAX_CHANNELS(MAX_CHANNELS)) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .go_i       (go),
    .sample_i   (s0_sample_r),
    .first_i    (s0_first_r),
    .last_i     (s0_last_r),
    .offset_i   (s0_off_r),
    .weight_i   (s0_wgt_r),
    .nch_i      (nch),
    .width_i    (width_eff),
    .ctrl_o     (ctrl),
    .tail_pix_o (tail_pix)
  );

  ssr_outbuf #(.MAX_CHANNELS(MAX_CHANNELS)) u_outbuf (
    .clk         (clk),
    .rst_n       (rst_n),
    .ld_i        (go),
    .ctrl_i      (ctrl),
    .tail_pix_i  (tail_pix),
    .free_o      (buf_free),
    .out_valid_o (out_tvalid),
    .out_ready_i (out_tready),
    .out_last_o  (out_tlast),
    .out_res_o   (out_res)
  );

  assign out_tdata = {out_res.chan, out_res.pos, out_res.pixel};
  assign out_tuser = out_res.tail;

endmodule

`default_nettype wire

/* dv/ssr_checker.sv */
// Scoreboard for the shear scanline resampler: watches the config port and both streams.
// Keeps its own copy of line state, predicts every output beat and compares in order.
// Depends on ssr_pkg.
`timescale 1ns / 1ps

module ssr_checker #(
  parameter int MAX_CHANNELS = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,   // sample[7:0], line_offset[23:8], line_weight[40:24]
  input  logic        in_tuser,   // first_of_line
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // pixel[7:0], dest_position[21:8], channel[23:22]
  input  logic        out_tuser,  // is_tail
  input  logic        out_tlast,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [14:0] cfg_wdata,
  output int          mismatch_count,
  output int          pixels_pending
);
  import ssr_pkg::*;

  localparam longint LEFT_MAX = 64'sd33554431;
  localparam longint LEFT_MIN = -64'sd33554432;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [POS_W-1:0] pos;
    logic [CH_W-1:0]  chan;
    logic             tail;
    logic             last;
  } pix_beat_t;

  pix_beat_t   expected_pixels[$];
  pix_beat_t   want;
  pix_beat_t   got;

  logic [1:0]  chan_count_reg;
  logic [14:0] dest_width_reg;
  longint      left_q16[MAX_CHANNELS];
  int          dest_ctr;
  int          chan_sel;
  longint      line_weight_q16;
  bit          line_halted;

  initial begin
    mismatch_count = 0;
    pixels_pending = 0;
  end

  function automatic longint sat26(longint v);
    if (v > LEFT_MAX) return LEFT_MAX;
    if (v < LEFT_MIN) return LEFT_MIN;
    return v;
  endfunction

  function automatic logic [PIX_W-1:0] clamp_pix(longint v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  function automatic pix_beat_t make_beat(longint v, int pos, int ch, bit tail);
    pix_beat_t b;
    b.pixel = clamp_pix(v);
    b.pos   = pos[POS_W-1:0];
    b.chan  = ch[CH_W-1:0];
    b.tail  = tail;
    b.last  = 1'b0;
    return b;
  endfunction

  // One accepted sample: update line state and queue the beats it produces
  task automatic resample_sample(input logic [7:0] smp, input logic first, input logic last,
                                 input logic [15:0] offs, input logic [16:0] wgt);
    int        nch;
    int        wid;
    int        pos;
    int        tpos;
    longint    total;
    longint    val;
    pix_beat_t run[$];

    nch = (chan_count_reg == 0) ? 1 :
          (chan_count_reg > MAX_CHANNELS) ? MAX_CHANNELS : int'(chan_count_reg);
    wid = (dest_width_reg > MAX_LINE_WIDTH) ? MAX_LINE_WIDTH : int'(dest_width_reg);

    if (first) begin
      for (int i = 0; i < MAX_CHANNELS; i++) left_q16[i] = 0;
      dest_ctr        = int'($signed(offs));
      line_weight_q16 = longint'(wgt);
      chan_sel        = 0;
      line_halted     = 1'b0;
    end
    if (line_halted) return;
    if (chan_sel >= nch) chan_sel = 0;

    pos = dest_ctr;
    if (pos >= wid) begin
      line_halted = 1'b1;
      return;
    end
    total = left_q16[chan_sel] + longint'(smp) * line_weight_q16 + 64'sd32768;
    val   = total / 64'sd65536;   // truncates toward zero
    left_q16[chan_sel] = sat26(left_q16[chan_sel] + longint'(smp) * 64'sd65536
                               - val * 64'sd65536);
    if (pos >= 0) run.push_back(make_beat(val, pos, chan_sel, 1'b0));
    chan_sel++;
    if (chan_sel >= nch) begin
      chan_sel = 0;
      if (dest_ctr < 32767) dest_ctr++;
    end

    if (last) begin
      // a half-finished pixel counts as complete for the tail position
      tpos = dest_ctr;
      if (chan_sel != 0 && tpos < 32767) tpos++;
      if (tpos >= 0 && tpos < wid) begin
        for (int c = 0; c < nch; c++)
          run.push_back(make_beat((left_q16[c] + 64'sd32768) / 64'sd65536, tpos, c, 1'b1));
      end
      line_halted = 1'b1;
    end

    if (run.size() > 0) run[run.size()-1].last = 1'b1;
    foreach (run[i]) expected_pixels.push_back(run[i]);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      chan_count_reg  = 2'd1;
      dest_width_reg  = 15'd16384;
      for (int i = 0; i < MAX_CHANNELS; i++) left_q16[i] = 0;
      dest_ctr        = 0;
      chan_sel        = 0;
      line_weight_q16 = 0;
      line_halted     = 1'b0;
      expected_pixels.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CHANNEL_COUNT: chan_count_reg = cfg_wdata[1:0];
          REG_DEST_WIDTH:    dest_width_reg = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        resample_sample(in_tdata[7:0], in_tuser, in_tlast, in_tdata[23:8], in_tdata[40:24]);
      if (out_tvalid && out_tready) begin
        got.pixel = out_tdata[7:0];
        got.pos   = out_tdata[21:8];
        got.chan  = out_tdata[23:22];
        got.tail  = out_tuser;
        got.last  = out_tlast;
        if (expected_pixels.size() == 0) begin
          $display("%0t: output beat with nothing expected: pixel %0d pos %0d ch %0d",
                   $time, got.pixel, got.pos, got.chan);
          mismatch_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (got.pixel !== want.pixel) begin
            $display("%0t: pixel expected %0d actual %0d", $time, want.pixel, got.pixel);
            mismatch_count++;
          end
          if (got.pos !== want.pos) begin
            $display("%0t: dest_position expected %0d actual %0d", $time, want.pos, got.pos);
            mismatch_count++;
          end
          if (got.chan !== want.chan) begin
            $display("%0t: channel expected %0d actual %0d", $time, want.chan, got.chan);
            mismatch_count++;
          end
          if (got.tail !== want.tail) begin
            $display("%0t: is_tail expected %0d actual %0d", $time, want.tail, got.tail);
            mismatch_count++;
          end
          if (got.last !== want.last) begin
            $display("%0t: last_of_run expected %0d actual %0d", $time, want.last, got.last);
            mismatch_count++;
          end
        end
      end
    end
    pixels_pending = expected_pixels.size();
  end

endmodule

/* dv/tb_top.sv */
// Top of the shear scanline resampler testbench: clock, reset, stimulus and verdict.
// Drives shear_scanline_resampler and hands the streams to ssr_checker for prediction.
// Depends on ssr_pkg, ssr_checker and the RTL.
`timescale 1ns / 1ps

module tb_top;
  import ssr_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;   // sample[7:0], line_offset[23:8], line_weight[40:24]
  logic        in_tuser = 1'b0; // first_of_line
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // pixel[7:0], dest_position[21:8], channel[23:22]
  logic        out_tuser;       // is_tail
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = REG_CHANNEL_COUNT;
  logic [14:0] cfg_wdata = '0;

  int          mismatch_count;
  int          pixels_pending;

  // percent chance per cycle that the sender holds off / the sink stalls
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          sent;

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  shear_scanline_resampler u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  ssr_checker u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .in_tlast       (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .pixels_pending (pixels_pending)
  );

  // Sink: random backpressure, updated on the falling edge only
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  // tvalid stays high on return so back-to-back beats need no extra assignment.
  task automatic push_sample(input int smp, input bit first, input bit last,
                             input int offs, input int wgt);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, 17'(wgt), 16'(offs), 8'(smp)};
    in_tuser  <= first;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Drop tvalid and wait until every predicted beat has come out, plus the
  // two-stage pipe, so an item with no result cannot still be in flight.
  task automatic drain_block();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pixels_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Both registers, written back to back while the block is idle
  task automatic set_line_format(input int nch, input int wid);
    drain_block();
    cfg_we    <= 1'b1;
    cfg_index <= REG_CHANNEL_COUNT;
    cfg_wdata <= 15'(nch);
    @(negedge clk);
    cfg_index <= REG_DEST_WIDTH;
    cfg_wdata <= 15'(wid);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One scanline with random content. nch is the effective channel count.
  // Mostly well-formed; sometimes cut mid-pixel or missing its last_of_line.
  task automatic random_line(input int nch, input int wid);
    int npix;
    int nsamp;
    int offs;
    int wgt;
    int smp;
    int edge_w;
    bit drop_last;

    edge_w    = (wid > MAX_LINE_WIDTH) ? MAX_LINE_WIDTH : wid;
    npix      = $urandom_range(1, 5);
    nsamp     = npix * nch;
    if (nch > 1 && $urandom_range(2) == 0) nsamp -= $urandom_range(1, nch - 1);
    drop_last = ($urandom_range(9) == 0);

    case ($urandom_range(9))
      0:       offs = int'($urandom_range(32768)) - 16384;       // anywhere in range
      1:       offs = edge_w - int'($urandom_range(2));          // runs into the right edge
      default: offs = int'($urandom_range(8)) - 3;               // near the left edge
    endcase
    case ($urandom_range(7))
      0:       wgt = 0;
      1:       wgt = 65536;                                      // weight of exactly 1.0
      default: wgt = $urandom_range(65535);
    endcase

    for (int i = 0; i < nsamp; i++) begin
      smp = ($urandom_range(5) == 0) ? ($urandom_range(1) ? 255 : 0) : $urandom_range(255);
      // offset and weight only matter on the first beat; scramble them elsewhere
      push_sample(smp, i == 0, (i == nsamp - 1) && !drop_last,
                  (i == 0) ? offs : int'($urandom_range(32768)) - 16384,
                  (i == 0) ? wgt : $urandom_range(65536));
    end
    sent += nsamp;
  endtask

  // Random traffic for one idle/stall profile and one line format
  task automatic random_phase(input int idle, input int stall, input int cc, input int wid,
                              input bit mid_pause);
    int nch;
    bit paused;

    nch = (cc == 0) ? 1 : cc;
    set_line_format(cc, wid);
    idle_pct  = idle;
    stall_pct = stall;
    paused    = 1'b0;
    sent      = 0;
    while (sent < 24) begin
      if ($urandom_range(9) == 0) begin
        // stray beat with random flags
        push_sample($urandom_range(255), $urandom_range(1), $urandom_range(1),
                    int'($urandom_range(32768)) - 16384, $urandom_range(65536));
        sent++;
      end else begin
        random_line(nch, wid);
      end
      if (mid_pause && !paused && sent >= 16) begin
        // sender holds off until the output side has fully caught up
        drain_block();
        paused = 1'b1;
      end
    end
  endtask

  // Run limit: far beyond the slowest legal run (every sample yielding up to four
  // beats, every beat stalled by the sink)
  initial begin
    #5_000_000;
    $display("shear_scanline_resampler verification failed");
    $finish;
  end

  initial begin
    // synchronous reset, released on a falling edge
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ---- directed: reset format, one channel, full width ----
    // samples before any line start run on the reset state (zero weight)
    push_sample(200, 1'b0, 1'b0, 0, 0);
    push_sample(255, 1'b0, 1'b1, 0, 0);
    // line starting left of the image: first two beats are dropped, full weight
    push_sample(255, 1'b1, 1'b0, -2, 65536);
    push_sample(0,   1'b0, 1'b0, 0, 0);
    push_sample(128, 1'b0, 1'b0, 0, 0);
    push_sample(17,  1'b0, 1'b1, 0, 0);
    // last legal position; the tail would land on dest_width and is suppressed
    push_sample(255, 1'b1, 1'b1, 16383, 32768);
    // starts at dest_width: stops at once, following beat ignored
    push_sample(9,   1'b1, 1'b0, 16384, 1);
    push_sample(1,   1'b0, 1'b1, 0, 0);
    // offset -16384, zero weight, tail also off-image
    push_sample(0,   1'b1, 1'b1, -16384, 0);

    // ---- directed: three channels, narrow line ----
    set_line_format(3, 3);
    push_sample(100, 1'b1, 1'b0, 1, 21845);
    push_sample(200, 1'b0, 1'b0, 0, 0);
    push_sample(50,  1'b0, 1'b0, 0, 0);
    push_sample(30,  1'b0, 1'b0, 0, 0);
    // ends mid-pixel; tail would be at position 3 = dest_width, dropped
    push_sample(40,  1'b0, 1'b1, 0, 0);
    // ends mid-pixel at 0: tail at 1 for all three channels (five beats in all)
    push_sample(255, 1'b1, 1'b0, 0, 49152);
    push_sample(7,   1'b0, 1'b1, 0, 0);
    // runs past dest_width: later beats, including last_of_line, are ignored
    push_sample(5,   1'b1, 1'b0, 1, 4660);
    push_sample(6,   1'b0, 1'b0, 0, 0);
    push_sample(7,   1'b0, 1'b0, 0, 0);
    push_sample(8,   1'b0, 1'b0, 0, 0);
    push_sample(9,   1'b0, 1'b0, 0, 0);
    push_sample(10,  1'b0, 1'b0, 0, 0);
    push_sample(11,  1'b0, 1'b0, 0, 0);
    push_sample(12,  1'b0, 1'b1, 0, 0);

    // zero width: every line stops before producing anything
    set_line_format(3, 0);
    push_sample(1,   1'b1, 1'b1, 0, 65536);

    // ---- random phases ----
    random_phase(0,  0,  3, 16384, 1'b0);
    random_phase(59, 0,  2, 7,     1'b0);
    random_phase(0,  59, 0, 32767, 1'b1);   // channel_count 0 acts as 1, width clipped
    random_phase(16, 16, 1, 12,    1'b0);

    drain_block();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("shear_scanline_resampler verification clean");
    end else begin
      $display("shear_scanline_resampler verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/ssr_pkg.sv
sv/ssr_engine.sv
sv/ssr_outbuf.sv
sv/shear_scanline_resampler.sv
dv/ssr_checker.sv
dv/tb_top.sv
